// File: hw/rtl/vector3_normalize_top_macros.svh
// Assertion macros used by the vector normalizer top level
`ifndef VECTOR3_NORMALIZE_TOP_MACROS_SVH
`define VECTOR3_NORMALIZE_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define VN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check an implication on every clock edge outside reset
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/vn_pkg.sv
// Shared types for the vector normalizer
package vn_pkg;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctrl_t;

  localparam int LANES = 3;

endpackage

// File: hw/rtl/vector3_normalize_top.sv
// Pipeline: front stages, one cell per quotient bit, output register.
// Throughput: one vector per cycle while no result waits at the output.
// The whole pipeline advances together; it stalls only while a result waits at the output.
// Reset: rst synchronous, active high, clears every valid flag; data registers are not reset.
// Top level of the 3-component vector normalizer
module vector3_normalize_top #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // vec_x, vec_y, vec_z
  input  logic [((3*IN_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // unit_x, unit_y, unit_z
  output logic [((3*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
  // was_zero
  output logic                                  m_tuser
);

  localparam int OB   = OUT_FRAC_BITS + 2;
  localparam int RW   = OUT_FRAC_BITS + 1;
  localparam int SW   = 2 * IN_WIDTH + 2;
  localparam int WW   = SW + 2 * OUT_FRAC_BITS + 3;
  localparam int NC   = OUT_FRAC_BITS + 1;
  localparam int ODW  = ((3 * OB + 7) / 8) * 8;
  localparam logic [RW-1:0] ONE = RW'(1) << OUT_FRAC_BITS;

  logic                                   en;
  logic [vn_pkg::LANES-1:0][IN_WIDTH-1:0] vec;
  vn_pkg::ctrl_t                          ctrl_w [NC+1];
  logic [NC:0][SW-1:0]                    s_w;
  logic [NC:0][vn_pkg::LANES-1:0][WW-1:0] t_w;
  logic [NC:0][vn_pkg::LANES-1:0][WW-1:0] a_w;
  logic [NC:0][vn_pkg::LANES-1:0][WW-1:0] b_w;
  logic [NC:0][vn_pkg::LANES-1:0][RW-1:0] r_w;
  logic [NC:0][vn_pkg::LANES-1:0]         neg_w;
  logic [vn_pkg::LANES-1:0][OB-1:0]       unit_next;
  logic [vn_pkg::LANES-1:0][OB-1:0]       unit;
  logic                                   in_range;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      vec[i] = s_tdata[i*IN_WIDTH +: IN_WIDTH];
    end
  end

  vn_front #(
    .IN_WIDTH      (IN_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS),
    .SW            (SW),
    .WW            (WW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .vec      (vec),
    .ctrl     (ctrl_w[0]),
    .sum_sq   (s_w[0]),
    .target   (t_w[0]),
    .neg      (neg_w[0])
  );

  assign a_w[0] = '0;
  assign b_w[0] = '0;
  assign r_w[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    vn_cell #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .BIT           (OUT_FRAC_BITS - k),
      .SW            (SW),
      .WW            (WW),
      .RW            (RW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl_w[k]),
      .s_in     (s_w[k]),
      .t_in     (t_w[k]),
      .a_in     (a_w[k]),
      .b_in     (b_w[k]),
      .r_in     (r_w[k]),
      .neg_in   (neg_w[k]),
      .ctrl_out (ctrl_w[k+1]),
      .s_out    (s_w[k+1]),
      .t_out    (t_w[k+1]),
      .a_out    (a_w[k+1]),
      .b_out    (b_w[k+1]),
      .r_out    (r_w[k+1]),
      .neg_out  (neg_w[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      if (ctrl_w[NC].zero) begin
        unit_next[i] = '0;
      end else if (r_w[NC][i] > ONE) begin
        unit_next[i] = neg_w[NC][i] ? -OB'(ONE) : OB'(ONE);
      end else begin
        unit_next[i] = neg_w[NC][i] ? -OB'(r_w[NC][i]) : OB'(r_w[NC][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctrl_w[NC].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit    <= unit_next;
      m_tuser <= ctrl_w[NC].zero;
    end
  end

  assign m_tdata = ODW'(unit);

  always_comb begin
    in_range = 1'b1;
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      if (($signed(unit[i]) > $signed(OB'(ONE))) || ($signed(unit[i]) < -$signed(OB'(ONE)))) begin
        in_range = 1'b0;
      end
    end
  end

`include "vector3_normalize_top_macros.svh"

  `VN_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "ready does not follow output stall")
  `VN_ASSERT_IMP(a_zero, m_tvalid && m_tuser, m_tdata == '0, "zero vector with nonzero output")
  `VN_ASSERT_IMP(a_range, m_tvalid, in_range, "output out of range")

endmodule

// File: hw/rtl/vn_front.sv
// Front stages: component magnitudes, squares, sum of squares and targets
module vn_front #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 14,
  parameter int SW            = 2 * IN_WIDTH + 2,
  parameter int WW            = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 5
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_valid,
  input  logic [vn_pkg::LANES-1:0][IN_WIDTH-1:0]    vec,
  output vn_pkg::ctrl_t                             ctrl,
  output logic [SW-1:0]                             sum_sq,
  output logic [vn_pkg::LANES-1:0][WW-1:0]          target,
  output logic [vn_pkg::LANES-1:0]                  neg
);

  logic [vn_pkg::LANES-1:0][IN_WIDTH-1:0]   mag;
  logic [vn_pkg::LANES-1:0]                 neg0;
  logic [vn_pkg::LANES-1:0]                 neg1;
  logic [vn_pkg::LANES-1:0][2*IN_WIDTH-1:0] sq;
  logic                                     valid0;
  logic                                     valid1;
  logic [SW-1:0]                            sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
      valid1 <= 1'b0;
      ctrl   <= '0;
    end else if (en) begin
      valid0 <= in_valid;
      valid1 <= valid0;
      ctrl   <= '{valid: valid1, zero: (sum_next == '0)};
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      sum_next = sum_next + SW'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < vn_pkg::LANES; i++) begin
        neg0[i]   <= vec[i][IN_WIDTH-1];
        mag[i]    <= vec[i][IN_WIDTH-1] ? (~vec[i] + 1'b1) : vec[i];
        neg1[i]   <= neg0[i];
        sq[i]     <= mag[i] * mag[i];
        neg[i]    <= neg1[i];
        target[i] <= WW'(sq[i]) << (2 * OUT_FRAC_BITS + 2);
      end
      sum_sq <= sum_next;
    end
  end

endmodule

// File: hw/rtl/vn_cell.sv
// One cell of the chain: decides one quotient bit for all three lanes
module vn_cell #(
  parameter int OUT_FRAC_BITS = 14,
  parameter int BIT           = 14,
  parameter int SW            = 34,
  parameter int WW            = 65,
  parameter int RW            = OUT_FRAC_BITS + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  vn_pkg::ctrl_t                        ctrl_in,
  input  logic [SW-1:0]                        s_in,
  input  logic [vn_pkg::LANES-1:0][WW-1:0]     t_in,
  input  logic [vn_pkg::LANES-1:0][WW-1:0]     a_in,
  input  logic [vn_pkg::LANES-1:0][WW-1:0]     b_in,
  input  logic [vn_pkg::LANES-1:0][RW-1:0]     r_in,
  input  logic [vn_pkg::LANES-1:0]             neg_in,
  output vn_pkg::ctrl_t                        ctrl_out,
  output logic [SW-1:0]                        s_out,
  output logic [vn_pkg::LANES-1:0][WW-1:0]     t_out,
  output logic [vn_pkg::LANES-1:0][WW-1:0]     a_out,
  output logic [vn_pkg::LANES-1:0][WW-1:0]     b_out,
  output logic [vn_pkg::LANES-1:0][RW-1:0]     r_out,
  output logic [vn_pkg::LANES-1:0]             neg_out
);

  localparam logic [RW-1:0] ONE  = RW'(1) << OUT_FRAC_BITS;
  localparam logic [RW-1:0] STEP = RW'(1) << BIT;

  logic [WW-1:0]                           s_w;
  logic [WW-1:0]                           sd;
  logic [WW-1:0]                           sdd;
  logic [vn_pkg::LANES-1:0][WW-1:0]        a_c;
  logic [vn_pkg::LANES-1:0][WW-1:0]        b_c;
  logic [vn_pkg::LANES-1:0][WW-1:0]        lhs;
  logic [vn_pkg::LANES-1:0][RW-1:0]        cand;
  logic [vn_pkg::LANES-1:0]                take;

  always_comb begin
    s_w = WW'(s_in);
    sd  = s_w << BIT;
    sdd = s_w << (2 * BIT);
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      cand[i] = r_in[i] + STEP;
      a_c[i]  = a_in[i] + ((b_in[i] << BIT) << 1) + sdd;
      b_c[i]  = b_in[i] + sd;
      lhs[i]  = (a_c[i] << 2) - (b_c[i] << 2) + s_w;
      take[i] = (cand[i] <= ONE) && (lhs[i] <= t_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_out   <= s_in;
      t_out   <= t_in;
      neg_out <= neg_in;
      for (int i = 0; i < vn_pkg::LANES; i++) begin
        a_out[i] <= take[i] ? a_c[i]  : a_in[i];
        b_out[i] <= take[i] ? b_c[i]  : b_in[i];
        r_out[i] <= take[i] ? cand[i] : r_in[i];
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench for the 3-component vector normalizer: stream stimulus and per-result checking
`timescale 1ns / 100ps

module tb_top;

  localparam int IN_W  = 16;
  localparam int FRAC  = 14;
  localparam int OUT_W = FRAC + 2;
  localparam int LAT   = FRAC + 5;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [OUT_W-1:0] ux;
    logic [OUT_W-1:0] uy;
    logic [OUT_W-1:0] uz;
    logic             zero;
  } unit_vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;

  unit_vec_t   unit_q[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          rx_stall_on = 1'b1;
  int          rx_gap = 0;

  vector3_normalize_top #(.IN_WIDTH(IN_W), .OUT_FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [IN_W:0] mag_of(logic [IN_W-1:0] v);
    return v[IN_W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  // nearest rounding, ties away: largest c with (2c-1)^2 * s <= 4 v^2 2^(2F)
  function automatic logic [OUT_W-1:0] scale_comp(logic [IN_W-1:0] v, logic [127:0] s);
    logic [127:0] m, lim, c, odd;
    logic [OUT_W-1:0] r;
    m = 128'(mag_of(v));
    lim = (m * m) << (2 * FRAC + 2);
    c = '0;
    for (int b = FRAC; b >= 0; b--) begin
      odd = 2 * (c | (128'd1 << b)) - 1;
      if ((c | (128'd1 << b)) <= (128'd1 << FRAC) && odd * odd * s <= lim)
        c = c | (128'd1 << b);
    end
    r = c[OUT_W-1:0];
    return v[IN_W-1] ? (~r + 1'b1) : r;
  endfunction

  function automatic unit_vec_t normalize(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                          logic [IN_W-1:0] z);
    unit_vec_t u;
    logic [127:0] s, mx, my, mz;
    mx = 128'(mag_of(x));
    my = 128'(mag_of(y));
    mz = 128'(mag_of(z));
    s = mx * mx + my * my + mz * mz;
    if (s == 0) begin
      u = '{ux: '0, uy: '0, uz: '0, zero: 1'b1};
    end else begin
      u.ux = scale_comp(x, s);
      u.uy = scale_comp(y, s);
      u.uz = scale_comp(z, s);
      u.zero = 1'b0;
    end
    return u;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_vec(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z,
                          bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    do @(posedge clk); while (!s_tready);
    unit_q.push_back(normalize(x, y, z));
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_sender();
    while (unit_q.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  // output side: random backpressure unless rx_stall_on is cleared, check each transaction
  always @(posedge clk) begin
    unit_vec_t exp_u;
    unit_vec_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{ux: m_tdata[15:0], uy: m_tdata[31:16], uz: m_tdata[47:32], zero: m_tuser};
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_u = unit_q.pop_front();
          if (got.ux !== exp_u.ux)
            $display("%0t: unit_x exp %0d got %0d", $time, $signed(exp_u.ux), $signed(got.ux));
          if (got.uy !== exp_u.uy)
            $display("%0t: unit_y exp %0d got %0d", $time, $signed(exp_u.uy), $signed(got.uy));
          if (got.uz !== exp_u.uz)
            $display("%0t: unit_z exp %0d got %0d", $time, $signed(exp_u.uz), $signed(got.uz));
          if (got.zero !== exp_u.zero)
            $display("%0t: was_zero exp %0b got %0b", $time, exp_u.zero, got.zero);
          if (got !== exp_u) errors++;
        end
      end
    end
    if (!rx_stall_on) begin
      m_tready <= 1'b1;
    end else if (rx_gap > 0) begin
      m_tready <= 1'b0;
      rx_gap   <= rx_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) rx_gap <= gap_len();
    end
  end

  task automatic test_directed();
    logic [IN_W-1:0] ext[6];
    ext = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555};
    send_vec(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vec(16'h8000, 16'h0000, 16'h0000, 1'b0);
    send_vec(16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    send_vec(16'h0000, 16'h0000, 16'h0001, 1'b0);
    send_vec(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_vec(16'h0001, 16'h0001, 16'h0000, 1'b0);
    send_vec(16'hFFFF, 16'h0002, 16'h0002, 1'b0);
    send_vec(16'h0003, 16'hFFFC, 16'h0000, 1'b0);
    for (int i = 0; i < 12; i++)
      send_vec(ext[$urandom_range(0, 5)], ext[$urandom_range(0, 5)],
               ext[$urandom_range(0, 5)], 1'b1);
    drain();
  endtask

  task automatic test_random();
    logic [IN_W-1:0] v[3];
    for (int i = 0; i < 1800; i++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 3))
          0: v[k] = 16'($urandom_range(0, 16'hFFFF));
          1: v[k] = 16'($urandom_range(0, 15) - 8);
          2: v[k] = $urandom_range(0, 1) ? 16'(16'h8000 + $urandom_range(0, 3))
                                         : 16'(16'h7FFF - $urandom_range(0, 3));
          default: v[k] = '0;
        endcase
      end
      rx_stall_on = !(i >= 600 && i < 800);
      send_vec(v[0], v[1], v[2], !(i >= 400 && i < 600));
      if (i == 1000) drain();
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/vn_pkg.sv
hw/rtl/vn_front.sv
hw/rtl/vn_cell.sv
hw/rtl/vector3_normalize_top.sv
tb/sv/tb_top.sv
